// File: hw/rtl/elb_pkg.sv
// Expert load balancer: shared constants, codes, command and status types.
// No dependencies; used by every module of the block.
package elb_pkg;

    localparam int EXPERT_CNT  = 16;
    localparam int MAX_CAND    = 8;
    localparam int COUNT_BITS  = 16;
    localparam int EID_W       = 4;
    localparam int CIDX_W      = 3;
    localparam int CCNT_W      = 4;
    localparam int DIV_W       = 52;
    localparam int DVS_W       = 16;
    localparam int DIV_CNT_W   = 6;

    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam logic [15:0] HALF_Q16    = 16'd32768;
    localparam logic [11:0] ALPHA_Q16   = 12'd3277;
    localparam logic [15:0] ONE_M_ALPHA = 16'd62259;
    localparam logic [16:0] MIN_FACTOR  = 17'd655;

    localparam logic [2:0] REG_EXPERTS  = 3'd0;
    localparam logic [2:0] REG_QUEUE    = 3'd1;
    localparam logic [2:0] REG_OVERLOAD = 3'd2;
    localparam logic [2:0] REG_GAIN     = 3'd3;
    localparam logic [2:0] REG_ADAPTIVE = 3'd4;

    typedef enum logic [1:0] {
        OP_SELECT = 2'd0,
        OP_START  = 2'd1,
        OP_DONE   = 2'd2,
        OP_FAIL   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_ID   = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        CMD_NONE, CMD_LOAD, CMD_CAND, CMD_INC, CMD_DEC, CMD_FAIL,
        CMD_EMA_MUL, CMD_EMA_WR, CMD_UTIL_DIV, CMD_UTIL_WR, CMD_OVL_MUL, CMD_OVL_WR,
        CMD_SUM, CMD_MEAN_DIV, CMD_MEAN_WR, CMD_SQ_MUL, CMD_SQ_ACC, CMD_VAR_DIV,
        CMD_VAR_WR, CMD_PEN_INIT, CMD_PEN_A, CMD_PEN_B, CMD_PEN_C, CMD_PICK_BEST,
        CMD_PICK_MUL, CMD_PICK_STEP, CMD_OUT
    } t_cmd;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_PEN_INIT, S_PEN_A, S_PEN_B, S_PEN_C, S_PICK_CHK,
        S_PICK_STEP, S_EMA_MUL, S_EMA_WR, S_UTIL_DIV, S_UTIL_WAIT, S_UTIL_WR,
        S_OVL_MUL, S_OVL_WR, S_SUM, S_MEAN_DIV, S_MEAN_WAIT, S_MEAN_WR, S_SQ_MUL,
        S_SQ_ACC, S_VAR_DIV, S_VAR_WAIT, S_VAR_WR, S_OUT
    } t_state;

    typedef struct packed {
        t_cmd    cmd;
        t_status status;
        logic    is_sel;
    } t_ctl;

    typedef struct packed {
        t_op  op;
        logic last;
        logic ovf_next;
        logic bad_id;
        logic cand_last;
        logic exp_last;
        logic div_done;
        logic any_bad;
        logic total_zero;
        logic found;
    } t_dp_stat;

endpackage

// File: hw/rtl/elb_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on elb_pkg.
module elb_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [elb_pkg::DIV_W-1:0]    i_dividend,
    input  logic [elb_pkg::DVS_W-1:0]    i_divisor,
    output logic                         o_done,
    output logic [elb_pkg::DIV_W-1:0]    o_quotient
);
    import elb_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0]     r_q;
    logic [DVS_W-1:0]     r_rem;
    logic [DVS_W-1:0]     r_dvs;
    logic [DVS_W:0]       trial;
    logic                 ge;
    logic [DVS_W:0]       diff;

    always_comb begin
        trial = {r_rem, r_q[DIV_W-1]};
        ge    = trial >= {1'b0, r_dvs};
        diff  = trial - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_W-2:0], ge};
            r_rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;
endmodule

// File: hw/rtl/elb_dp.sv
// Datapath: configuration, per-expert state, candidate buffer, arithmetic.
// Depends on elb_pkg and elb_div; driven by commands from elb_ctrl.
module elb_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  elb_pkg::t_ctl             i_ctl,
    output elb_pkg::t_dp_stat         o_stat,
    input  logic                      i_cfg_we,
    input  logic [2:0]                i_cfg_index,
    input  logic [16:0]               i_cfg_data,
    input  logic [1:0]                i_op,
    input  logic [3:0]                i_expert,
    input  logic [15:0]               i_weight,
    input  logic                      i_last_candidate,
    input  logic [15:0]               i_random_fraction,
    output logic                      o_valid,
    output logic [1:0]                o_status,
    output logic                      o_is_selection,
    output logic [3:0]                o_chosen_expert,
    output logic                      o_balanced,
    output logic [31:0]               o_load_variance
);
    import elb_pkg::*;

    // configuration
    logic [4:0]  r_cfg_n;
    logic [15:0] r_cfg_q;
    logic [16:0] r_cfg_ol;
    logic [16:0] r_cfg_gain;
    logic        r_cfg_adapt;

    // latched item
    logic [1:0]  r_op;
    logic [EID_W-1:0] r_e;
    logic [15:0] r_w;
    logic        r_last;
    logic [15:0] r_rf;

    // expert state
    logic [COUNT_BITS-1:0] r_active [EXPERT_CNT];
    logic [31:0] r_hist [EXPERT_CNT];
    logic [16:0] r_util [EXPERT_CNT];
    logic [EXPERT_CNT-1:0] r_ovl;
    logic [31:0] r_var;

    // candidate buffer
    logic [EID_W-1:0] r_cid [MAX_CAND];
    logic [15:0] r_cw [MAX_CAND];
    logic [CCNT_W-1:0] r_ccnt;
    logic        r_covf;

    // work registers
    logic [EID_W-1:0] r_idx;
    logic [63:0] r_prod;
    logic [DIV_W-1:0] r_acc;
    logic [31:0] r_mean;
    logic [CIDX_W-1:0] r_best;
    logic [16:0] r_best_util;
    logic        r_bad;
    logic [18:0] r_cum;
    logic [EID_W-1:0] r_pick;

    // result register
    logic        r_o_valid;
    logic [1:0]  r_o_status;
    logic        r_o_sel;
    logic [EID_W-1:0] r_o_chosen;
    logic        r_o_bal;
    logic [31:0] r_o_var;

    logic [4:0]  n_eff;
    logic [15:0] q_eff;
    logic [EID_W-1:0] cur_cid;
    logic [15:0] cur_cw;
    logic [16:0] util_c;
    logic [31:0] hist_i;
    logic [COUNT_BITS-1:0] act_e;
    logic [17:0] pen;
    logic [16:0] factor;
    logic [18:0] cum_nx;
    logic [18:0] rr;
    logic [31:0] h_dev;
    logic [33:0] ema_sum;
    logic [4:0]  ovl_cnt;
    logic        bal;
    logic        div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;
    logic        div_done;
    logic [DIV_W-1:0] div_q;

    elb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_comb begin
        n_eff = (r_cfg_n == 5'd0) ? 5'd1 :
                (r_cfg_n > 5'(EXPERT_CNT)) ? 5'(EXPERT_CNT) : r_cfg_n;
        q_eff   = (r_cfg_q == 16'd0) ? 16'd1 : r_cfg_q;
        cur_cid = r_cid[r_idx[CIDX_W-1:0]];
        cur_cw  = r_cw[r_idx[CIDX_W-1:0]];
        util_c  = r_util[cur_cid];
        hist_i  = r_hist[r_idx];
        act_e   = r_active[r_e];
        pen     = r_prod[33:16];
        if (!r_cfg_adapt) begin
            factor = ONE_Q16;
        end else if (r_ovl[cur_cid]) begin
            factor = MIN_FACTOR;
        end else begin
            factor = (pen >= 18'(ONE_Q16)) ? 17'd0 : 17'(18'(ONE_Q16) - pen);
            if (factor < MIN_FACTOR) begin
                factor = MIN_FACTOR;
            end
        end
        cum_nx  = r_cum + 19'(cur_cw);
        rr      = r_prod[34:16];
        h_dev   = (hist_i >= r_mean) ? hist_i - r_mean : r_mean - hist_i;
        ema_sum = 34'(28'(ALPHA_Q16) * 28'(act_e))
                + 34'((r_prod[47:0] + 48'(HALF_Q16)) >> 16);
        ovl_cnt = '0;
        for (int i = 0; i < EXPERT_CNT; i++) begin
            if (5'(i) < n_eff && r_ovl[i]) begin
                ovl_cnt = ovl_cnt + 5'd1;
            end
        end
        bal = (r_var <= 32'(HALF_Q16)) && (ovl_cnt <= (n_eff >> 1));

        div_start    = 1'b0;
        div_dividend = {r_acc[DIV_W-1:0]};
        div_divisor  = {11'd0, n_eff};
        case (i_ctl.cmd)
            CMD_UTIL_DIV: begin
                div_start    = 1'b1;
                div_dividend = DIV_W'({act_e, 16'h0});
                div_divisor  = q_eff;
            end
            CMD_MEAN_DIV, CMD_VAR_DIV: begin
                div_start = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_stat.op         = t_op'(r_op);
        o_stat.last       = r_last;
        o_stat.ovf_next   = r_covf || (r_ccnt == CCNT_W'(MAX_CAND));
        o_stat.bad_id     = {1'b0, r_e} >= n_eff;
        o_stat.cand_last  = r_idx == EID_W'(r_ccnt - 1'b1);
        o_stat.exp_last   = {1'b0, r_idx} == (n_eff - 5'd1);
        o_stat.div_done   = div_done;
        o_stat.any_bad    = r_bad;
        o_stat.total_zero = r_acc == '0;
        o_stat.found      = rr < cum_nx;
    end

    // control state and per-expert state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_n     <= 5'd16;
            r_cfg_q     <= 16'd64;
            r_cfg_ol    <= 17'd52429;
            r_cfg_gain  <= 17'd32768;
            r_cfg_adapt <= 1'b1;
            for (int i = 0; i < EXPERT_CNT; i++) begin
                r_active[i] <= '0;
                r_hist[i]   <= '0;
                r_util[i]   <= '0;
            end
            r_ovl     <= '0;
            r_var     <= '0;
            r_ccnt    <= '0;
            r_covf    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_EXPERTS:  r_cfg_n     <= i_cfg_data[4:0];
                    REG_QUEUE:    r_cfg_q     <= i_cfg_data[15:0];
                    REG_OVERLOAD: r_cfg_ol    <= i_cfg_data;
                    REG_GAIN:     r_cfg_gain  <= i_cfg_data;
                    REG_ADAPTIVE: r_cfg_adapt <= i_cfg_data[0];
                    default: ;
                endcase
            end
            r_o_valid <= i_ctl.cmd == CMD_OUT;
            case (i_ctl.cmd)
                CMD_CAND: begin
                    if (r_ccnt < CCNT_W'(MAX_CAND)) begin
                        r_ccnt <= r_ccnt + 1'b1;
                    end else begin
                        r_covf <= 1'b1;
                    end
                end
                CMD_INC: begin
                    if (act_e != '1) begin
                        r_active[r_e] <= act_e + 1'b1;
                    end
                end
                CMD_DEC: begin
                    if (act_e != '0) begin
                        r_active[r_e] <= act_e - 1'b1;
                    end
                end
                CMD_FAIL: begin
                    r_ovl[r_e]  <= 1'b1;
                    r_util[r_e] <= ONE_Q16;
                end
                CMD_EMA_WR: begin
                    r_hist[r_e] <= (|ema_sum[33:32]) ? 32'hFFFF_FFFF : ema_sum[31:0];
                end
                CMD_UTIL_WR: begin
                    r_util[r_e] <= (div_q > DIV_W'(ONE_Q16)) ? ONE_Q16 : div_q[16:0];
                end
                CMD_OVL_WR: begin
                    r_ovl[r_e] <= {1'b0, act_e, 16'h0} > r_prod[32:0];
                end
                CMD_VAR_WR: begin
                    r_var <= (|div_q[DIV_W-1:32]) ? 32'hFFFF_FFFF : div_q[31:0];
                end
                CMD_OUT: begin
                    if (i_ctl.is_sel) begin
                        r_ccnt <= '0;
                        r_covf <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload, candidate entries, work and result registers
    always_ff @(posedge i_clk) begin
        case (i_ctl.cmd)
            CMD_LOAD: begin
                r_op   <= i_op;
                r_e    <= i_expert;
                r_w    <= i_weight;
                r_last <= i_last_candidate;
                r_rf   <= i_random_fraction;
            end
            CMD_CAND: begin
                if (r_ccnt < CCNT_W'(MAX_CAND)) begin
                    r_cid[r_ccnt[CIDX_W-1:0]] <= r_e;
                    r_cw[r_ccnt[CIDX_W-1:0]]  <= r_w;
                end
            end
            CMD_EMA_MUL: r_prod <= 64'(48'(ONE_M_ALPHA) * 48'(r_hist[r_e]));
            CMD_OVL_MUL: r_prod <= 64'(33'(r_cfg_ol) * 33'(q_eff));
            CMD_OVL_WR, CMD_MEAN_WR: begin
                r_idx <= '0;
                r_acc <= '0;
                if (i_ctl.cmd == CMD_MEAN_WR) begin
                    r_mean <= div_q[31:0];
                end
            end
            CMD_SUM: begin
                r_acc <= r_acc + DIV_W'(hist_i);
                r_idx <= r_idx + 1'b1;
            end
            CMD_SQ_MUL: r_prod <= 64'(h_dev) * 64'(h_dev);
            CMD_SQ_ACC: begin
                r_acc <= r_acc + DIV_W'(r_prod[63:16]);
                r_idx <= r_idx + 1'b1;
            end
            CMD_PEN_INIT: begin
                r_idx <= '0;
                r_acc <= '0;
                r_bad <= 1'b0;
            end
            CMD_PEN_A: begin
                r_prod <= 64'(34'(util_c) * 34'(r_cfg_gain));
                if ({1'b0, cur_cid} >= n_eff) begin
                    r_bad <= 1'b1;
                end
                if (r_idx == '0 || util_c < r_best_util) begin
                    r_best      <= r_idx[CIDX_W-1:0];
                    r_best_util <= util_c;
                end
            end
            CMD_PEN_B: r_prod <= 64'(33'(cur_cw) * 33'(factor));
            CMD_PEN_C: begin
                r_cw[r_idx[CIDX_W-1:0]] <= r_prod[31:16];
                r_acc <= r_acc + DIV_W'(r_prod[31:16]);
                r_idx <= r_idx + 1'b1;
            end
            CMD_PICK_BEST: r_pick <= r_cid[r_best];
            CMD_PICK_MUL: begin
                r_prod <= 64'(35'(r_rf) * 35'(r_acc[18:0]));
                r_idx  <= '0;
                r_cum  <= '0;
            end
            CMD_PICK_STEP: begin
                r_cum  <= cum_nx;
                r_idx  <= r_idx + 1'b1;
                r_pick <= cur_cid;
            end
            CMD_OUT: begin
                r_o_status <= i_ctl.status;
                r_o_sel    <= i_ctl.is_sel;
                r_o_chosen <= (i_ctl.is_sel && i_ctl.status == ST_OK) ? r_pick : '0;
                r_o_bal    <= bal;
                r_o_var    <= r_var;
            end
            default: ;
        endcase
    end

    assign o_valid         = r_o_valid;
    assign o_status        = r_o_status;
    assign o_is_selection  = r_o_sel;
    assign o_chosen_expert = r_o_chosen;
    assign o_balanced      = r_o_bal;
    assign o_load_variance = r_o_var;
endmodule

// File: hw/rtl/elb_ctrl.sv
// Controller state machine: sequences datapath commands for each item.
// Depends on elb_pkg.
module elb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  elb_pkg::t_dp_stat i_stat,
    output elb_pkg::t_ctl     o_ctl
);
    import elb_pkg::*;

    t_state  r_state, n_state;
    t_status r_status, n_status;
    logic    r_is_sel, n_is_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_status <= ST_OK;
            r_is_sel <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_is_sel <= n_is_sel;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_status     = r_status;
        n_is_sel     = r_is_sel;
        o_ctl.cmd    = CMD_NONE;
        o_ctl.status = r_status;
        o_ctl.is_sel = r_is_sel;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.cmd = CMD_LOAD;
                    n_status  = ST_OK;
                    n_is_sel  = 1'b0;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.op == OP_SELECT) begin
                    o_ctl.cmd = CMD_CAND;
                    if (!i_stat.last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_is_sel = 1'b1;
                        if (i_stat.ovf_next) begin
                            n_status = ST_OVERFLOW;
                            n_state  = S_OUT;
                        end else begin
                            n_state = S_PEN_INIT;
                        end
                    end
                end else if (i_stat.bad_id) begin
                    n_status = ST_BAD_ID;
                    n_state  = S_OUT;
                end else if (i_stat.op == OP_START) begin
                    o_ctl.cmd = CMD_INC;
                    n_state   = S_OUT;
                end else if (i_stat.op == OP_DONE) begin
                    o_ctl.cmd = CMD_DEC;
                    n_state   = S_EMA_MUL;
                end else begin
                    o_ctl.cmd = CMD_FAIL;
                    n_state   = S_OUT;
                end
            end
            S_PEN_INIT: begin
                o_ctl.cmd = CMD_PEN_INIT;
                n_state   = S_PEN_A;
            end
            S_PEN_A: begin
                o_ctl.cmd = CMD_PEN_A;
                n_state   = S_PEN_B;
            end
            S_PEN_B: begin
                o_ctl.cmd = CMD_PEN_B;
                n_state   = S_PEN_C;
            end
            S_PEN_C: begin
                o_ctl.cmd = CMD_PEN_C;
                n_state   = i_stat.cand_last ? S_PICK_CHK : S_PEN_A;
            end
            S_PICK_CHK: begin
                if (i_stat.any_bad) begin
                    n_status = ST_BAD_ID;
                    n_state  = S_OUT;
                end else if (i_stat.total_zero) begin
                    o_ctl.cmd = CMD_PICK_BEST;
                    n_state   = S_OUT;
                end else begin
                    o_ctl.cmd = CMD_PICK_MUL;
                    n_state   = S_PICK_STEP;
                end
            end
            S_PICK_STEP: begin
                o_ctl.cmd = CMD_PICK_STEP;
                if (i_stat.found || i_stat.cand_last) begin
                    n_state = S_OUT;
                end
            end
            S_EMA_MUL: begin
                o_ctl.cmd = CMD_EMA_MUL;
                n_state   = S_EMA_WR;
            end
            S_EMA_WR: begin
                o_ctl.cmd = CMD_EMA_WR;
                n_state   = S_UTIL_DIV;
            end
            S_UTIL_DIV: begin
                o_ctl.cmd = CMD_UTIL_DIV;
                n_state   = S_UTIL_WAIT;
            end
            S_UTIL_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_UTIL_WR;
                end
            end
            S_UTIL_WR: begin
                o_ctl.cmd = CMD_UTIL_WR;
                n_state   = S_OVL_MUL;
            end
            S_OVL_MUL: begin
                o_ctl.cmd = CMD_OVL_MUL;
                n_state   = S_OVL_WR;
            end
            S_OVL_WR: begin
                o_ctl.cmd = CMD_OVL_WR;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_ctl.cmd = CMD_SUM;
                if (i_stat.exp_last) begin
                    n_state = S_MEAN_DIV;
                end
            end
            S_MEAN_DIV: begin
                o_ctl.cmd = CMD_MEAN_DIV;
                n_state   = S_MEAN_WAIT;
            end
            S_MEAN_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_MEAN_WR;
                end
            end
            S_MEAN_WR: begin
                o_ctl.cmd = CMD_MEAN_WR;
                n_state   = S_SQ_MUL;
            end
            S_SQ_MUL: begin
                o_ctl.cmd = CMD_SQ_MUL;
                n_state   = S_SQ_ACC;
            end
            S_SQ_ACC: begin
                o_ctl.cmd = CMD_SQ_ACC;
                n_state   = i_stat.exp_last ? S_VAR_DIV : S_SQ_MUL;
            end
            S_VAR_DIV: begin
                o_ctl.cmd = CMD_VAR_DIV;
                n_state   = S_VAR_WAIT;
            end
            S_VAR_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_VAR_WR;
                end
            end
            S_VAR_WR: begin
                o_ctl.cmd = CMD_VAR_WR;
                n_state   = S_OUT;
            end
            S_OUT: begin
                o_ctl.cmd = CMD_OUT;
                n_state   = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = r_state != S_IDLE;
endmodule

// File: hw/rtl/expert_load_balancer_top.sv
// Expert load balancer top level: controller, datapath and divider.
// Depends on elb_pkg, elb_ctrl, elb_dp (which holds elb_div).
//
//  channel | signals                                        | transfer
//  --------+------------------------------------------------+---------------------------
//  item    | i_op i_expert i_weight i_last_candidate        | i_start high, o_busy low
//          | i_random_fraction                              |
//  result  | o_status o_is_selection o_chosen_expert        | o_valid high, one cycle
//          | o_balanced o_load_variance                     |
//  config  | i_cfg_index i_cfg_data                         | i_cfg_we high
//
// One item at a time. A candidate that is not last is buffered with no result;
// start, failure, a bad id and a buffer overflow go straight to the result. A last
// candidate scales each buffered weight, then reports a bad id, picks the least
// utilised candidate for a zero total, or walks the candidates for the weighted pick.
// A completion runs three divisions of a 52-bit dividend by a 16-bit divisor and
// walks the tracked experts twice. The result is registered from the output step.
// Reset is synchronous, active low; it restores register defaults and clears all
// expert state. The receiver cannot stall results.
module expert_load_balancer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_op,
    input  logic [3:0]  i_expert,
    input  logic [15:0] i_weight,
    input  logic        i_last_candidate,
    input  logic [15:0] i_random_fraction,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic        o_is_selection,
    output logic [3:0]  o_chosen_expert,
    output logic        o_balanced,
    output logic [31:0] o_load_variance
);
    import elb_pkg::*;

    t_ctl     ctl;
    t_dp_stat stat;

    elb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    elb_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (ctl),
        .o_stat            (stat),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_op              (i_op),
        .i_expert          (i_expert),
        .i_weight          (i_weight),
        .i_last_candidate  (i_last_candidate),
        .i_random_fraction (i_random_fraction),
        .o_valid           (o_valid),
        .o_status          (o_status),
        .o_is_selection    (o_is_selection),
        .o_chosen_expert   (o_chosen_expert),
        .o_balanced        (o_balanced),
        .o_load_variance   (o_load_variance)
    );
endmodule
